// ----- hw/rtl/pwlt_pkg.sv -----
// Shared types and constants for the piecewise linear lookup table.
`default_nettype none

package pwlt_pkg;

   // Field widths
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 6;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 32;
   localparam int REGION_W   = 2;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int DIV_STEPS  = DATA_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   typedef logic signed [DATA_W-1:0] coord_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   typedef enum logic [REGION_W-1:0] {
      REGION_INTERP = 2'd0,
      REGION_FIRST  = 2'd1,
      REGION_LAST   = 2'd2,
      REGION_NONE   = 2'd3
   } region_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   // Operands of one interpolation: ya + sign * mag * offset / span
   typedef struct packed {
      coord_type         ya;
      logic              neg;
      logic [DATA_W-1:0] mag;
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] span;
   } interp_req_type;

   typedef struct packed {
      logic      done;
      coord_type value;
   } interp_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCHL,
      ST_DECIDE,
      ST_SCAN,
      ST_START,
      ST_WAIT,
      ST_RESULT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      IS_IDLE,
      IS_MUL,
      IS_DIV,
      IS_FIN
   } interp_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/pwlt_store.sv -----
// Breakpoint memory with per-entry valid bits and used-count tracking.
`default_nettype none

module pwlt_store #(
   parameter int TABLE_POINTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [$clog2(TABLE_POINTS)-1:0]    wr_addr,
   input  pwlt_pkg::point_type                wr_point,
   input  logic                               rd_en,
   input  logic [$clog2(TABLE_POINTS)-1:0]    rd_addr,
   output pwlt_pkg::point_type                rd_point,
   output logic [$clog2(TABLE_POINTS+1)-1:0]  count,
   output logic                               busy
);

   localparam int AW = $clog2(TABLE_POINTS);
   localparam int CW = $clog2(TABLE_POINTS + 1);

   pwlt_pkg::point_type mem [TABLE_POINTS];
   pwlt_pkg::point_type rd_data_ff;
   logic                rd_hit_ff;

   logic [TABLE_POINTS-1:0] valid_ff, valid_in;
   logic [TABLE_POINTS-1:0] nz_ff, nz_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    scan_ff, scan_in;
   logic [AW-1:0]           scan_idx_ff, scan_idx_in;
   logic                    wr_nz;
   logic [CW-1:0]           wr_top;

   // Memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_point;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   // Entries not written since the last new table read as zero
   assign rd_point = rd_hit_ff ? rd_data_ff : '0;
   assign count    = count_ff;
   assign busy     = scan_ff;

   // Valid / nonzero flags and used count; walk down when the top point goes to zero
   always_comb begin
      valid_in    = valid_ff;
      nz_in       = nz_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      scan_idx_in = scan_idx_ff;
      wr_nz       = (wr_point.x != '0) || (wr_point.y != '0);
      wr_top      = CW'(wr_addr) + CW'(1);
      if (wr_en) begin
         if (wr_addr == '0) begin
            valid_in    = '0;
            valid_in[0] = 1'b1;
            nz_in       = '0;
            nz_in[0]    = wr_nz;
            count_in    = wr_nz ? CW'(1) : '0;
         end else begin
            valid_in[wr_addr] = 1'b1;
            nz_in[wr_addr]    = wr_nz;
            if (wr_nz && (wr_top > count_ff)) begin
               count_in = wr_top;
            end else if (!wr_nz && (wr_top == count_ff)) begin
               scan_in     = 1'b1;
               scan_idx_in = wr_addr - AW'(1);
            end
         end
      end else if (scan_ff) begin
         if (nz_ff[scan_idx_ff]) begin
            count_in = CW'(scan_idx_ff) + CW'(1);
            scan_in  = 1'b0;
         end else if (scan_idx_ff == '0) begin
            count_in = '0;
            scan_in  = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff - AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         nz_ff       <= '0;
         count_ff    <= '0;
         scan_ff     <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         nz_ff       <= nz_in;
         count_ff    <= count_in;
         scan_ff     <= scan_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_POINTS))
      else $error("used count beyond table size");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !scan_ff)
      else $error("write while count walk in progress");

   a_count_top_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!scan_ff && (count_ff != '0)) |-> nz_ff[AW'(count_ff - CW'(1))])
      else $error("top counted point is zero");

endmodule

`default_nettype wire

// ----- hw/rtl/pwlt_interp.sv -----
// Interpolation unit: one 32x32 multiply, then a bit-serial 64/32 divide.
`default_nettype none

module pwlt_interp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pwlt_pkg::interp_req_type req,
   output pwlt_pkg::interp_rsp_type rsp
);

   localparam int DW = pwlt_pkg::DATA_W;
   localparam int PW = pwlt_pkg::PROD_W;
   localparam int SW = pwlt_pkg::STEP_W;

   pwlt_pkg::interp_state_type state_ff, state_in;
   pwlt_pkg::interp_req_type   req_ff, req_in;
   logic [DW-1:0]              rem_ff, rem_in;
   logic [DW-1:0]              quo_ff, quo_in;
   logic [SW-1:0]              step_ff, step_in;
   logic                       done_ff, done_in;
   pwlt_pkg::coord_type        value_ff, value_in;

   logic [PW-1:0] prod;
   logic [DW:0]   shifted;
   logic [DW+1:0] ya_ext;
   logic [DW+1:0] quo_ext;
   logic [DW+1:0] sum;

   // Sequencer: latch, multiply, 32 restoring divide steps, apply sign
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      prod     = PW'(req_ff.mag) * PW'(req_ff.offset);
      shifted  = {rem_ff, quo_ff[DW-1]};
      ya_ext   = {{2{req_ff.ya[DW-1]}}, req_ff.ya};
      quo_ext  = {2'b00, quo_ff};
      sum      = req_ff.neg ? (ya_ext - quo_ext) : (ya_ext + quo_ext);
      case (state_ff)
         pwlt_pkg::IS_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = pwlt_pkg::IS_MUL;
            end
         end
         pwlt_pkg::IS_MUL: begin
            // upper half is below the divisor, so the quotient fits 32 bits
            rem_in   = prod[PW-1:DW];
            quo_in   = prod[DW-1:0];
            step_in  = '1;
            state_in = pwlt_pkg::IS_DIV;
         end
         pwlt_pkg::IS_DIV: begin
            if (shifted >= {1'b0, req_ff.span}) begin
               rem_in = DW'(shifted - {1'b0, req_ff.span});
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = shifted[DW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = pwlt_pkg::IS_FIN;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         pwlt_pkg::IS_FIN: begin
            value_in = sum[DW-1:0];
            done_in  = 1'b1;
            state_in = pwlt_pkg::IS_IDLE;
         end
         default: begin
            state_in = pwlt_pkg::IS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwlt_pkg::IS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

   // Checks
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == pwlt_pkg::IS_IDLE))
      else $error("start while unit busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

   a_offset_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwlt_pkg::IS_MUL) |-> (req_ff.offset <= req_ff.span))
      else $error("query offset outside segment");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwlt_pkg::IS_DIV) |-> (rem_ff < req_ff.span))
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ----- hw/rtl/piecewise_linear_table.sv -----
// Piecewise linear lookup table: top level with the evaluation sequencer.
//
// Input beats (req_*) carry either a breakpoint write or an evaluate request,
// selected by req_tuser. A write at index 0 starts a new table; writes past
// the table size are dropped. Writes produce no output beat. Every evaluate
// produces one output beat (rsp_*): the value and its region code.
// If a write zeroes the topmost used point, the used count is rebuilt by
// walking down the nonzero flags, one point a cycle, and no input beat is
// taken meanwhile. An evaluate on an empty table goes straight to the result
// state; one that clamps or sees equal first x values is decided after the
// first, second and last points are fetched. A query in range walks the
// segments through the point memory (one entry a cycle, at most
// TABLE_POINTS-1 entries), then, when a segment matches, runs one multiply
// and a 32-step serial divide. Items are handled one at a time; the next
// beat can be taken in the cycle after the result is loaded.
// Reset empties the table (all points read as zero) and clears the count.
// The result sits in an output register; while the receiver stalls the block
// still accepts the next beat and only waits when a second result is ready.
`default_nettype none

module piecewise_linear_table #(
   parameter int TABLE_POINTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [5:0] point_index, [37:6] point_x, [69:38] point_y,
   // [101:70] query_value, [103:102] zero
   input  logic [pwlt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] operation
   input  logic [0:0]                          req_tuser,
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] result_value
   output logic [pwlt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] region
   output logic [pwlt_pkg::REGION_W-1:0]       rsp_tuser
);

   localparam int AW = $clog2(TABLE_POINTS);
   localparam int CW = $clog2(TABLE_POINTS + 1);
   localparam int DW = pwlt_pkg::DATA_W;
   localparam int IW = pwlt_pkg::IDX_W;

   // Unpacked input fields
   pwlt_pkg::op_type    in_op;
   logic [IW-1:0]       in_index;
   pwlt_pkg::coord_type in_x;
   pwlt_pkg::coord_type in_y;
   pwlt_pkg::coord_type in_query;
   logic                accept;

   // Store interface
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   pwlt_pkg::point_type wr_point;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   pwlt_pkg::point_type rd_point;
   logic [CW-1:0]       count;
   logic                store_busy;
   logic [AW-1:0]       last_addr;

   // Interpolation unit interface
   logic                     istart;
   pwlt_pkg::interp_req_type ireq;
   pwlt_pkg::interp_rsp_type irsp;

   // Sequencer state
   pwlt_pkg::ctrl_state_type state_ff, state_in;
   pwlt_pkg::coord_type      query_ff, query_in;
   pwlt_pkg::point_type      p0_ff, p0_in;
   pwlt_pkg::coord_type      x1_ff, x1_in;
   pwlt_pkg::point_type      hi_ff, hi_in;
   pwlt_pkg::point_type      a_ff, a_in;
   pwlt_pkg::point_type      b_ff, b_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic                     desc_ff, desc_in;
   pwlt_pkg::coord_type      res_value_ff, res_value_in;
   pwlt_pkg::region_type     res_region_ff, res_region_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   pwlt_pkg::coord_type      rsp_data_ff, rsp_data_in;
   pwlt_pkg::region_type     rsp_region_ff, rsp_region_in;

   logic seg_hit;

   assign in_op    = pwlt_pkg::op_type'(req_tuser[0]);
   assign in_index = req_tdata[IW-1:0];
   assign in_x     = req_tdata[IW+DW-1:IW];
   assign in_y     = req_tdata[IW+2*DW-1:IW+DW];
   assign in_query = req_tdata[IW+3*DW-1:IW+2*DW];

   assign req_tready = (state_ff == pwlt_pkg::ST_IDLE) && !store_busy;
   assign accept     = req_tvalid && req_tready;

   // Breakpoint writes go straight to the store
   assign wr_en      = accept && (in_op == pwlt_pkg::OP_WRITE) && (int'(in_index) < TABLE_POINTS);
   assign wr_addr    = AW'(in_index);
   assign wr_point.x = in_x;
   assign wr_point.y = in_y;
   assign last_addr  = AW'(count - CW'(1));

   pwlt_store #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_point (wr_point),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_point (rd_point),
      .count    (count),
      .busy     (store_busy)
   );

   // Segment operands: a is the lower-x end, b the upper-x end
   assign ireq.ya     = a_ff.y;
   assign ireq.neg    = b_ff.y < a_ff.y;
   assign ireq.mag    = (b_ff.y < a_ff.y) ? DW'(a_ff.y - b_ff.y) : DW'(b_ff.y - a_ff.y);
   assign ireq.offset = DW'(query_ff - a_ff.x);
   assign ireq.span   = DW'(b_ff.x - a_ff.x);

   pwlt_interp u_interp (
      .clock (clock),
      .reset (reset),
      .start (istart),
      .req   (ireq),
      .rsp   (irsp)
   );

   // Segment test: ascending takes (lo, hi], descending [hi, lo)
   assign seg_hit = desc_ff ? ((hi_ff.x <= query_ff) && (query_ff < rd_point.x))
                            : ((rd_point.x < query_ff) && (query_ff <= hi_ff.x));

   // Evaluation sequencer
   always_comb begin
      state_in      = state_ff;
      query_in      = query_ff;
      p0_in         = p0_ff;
      x1_in         = x1_ff;
      hi_in         = hi_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      idx_in        = idx_ff;
      desc_in       = desc_ff;
      res_value_in  = res_value_ff;
      res_region_in = res_region_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      istart        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_region_in = rsp_region_ff;
      case (state_ff)
         pwlt_pkg::ST_IDLE: begin
            if (accept && (in_op == pwlt_pkg::OP_EVAL)) begin
               query_in = in_query;
               if (count == '0) begin
                  res_value_in  = '0;
                  res_region_in = pwlt_pkg::REGION_NONE;
                  state_in      = pwlt_pkg::ST_RESULT;
               end else begin
                  state_in = pwlt_pkg::ST_FETCH0;
               end
            end
         end
         pwlt_pkg::ST_FETCH0: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = pwlt_pkg::ST_FETCH1;
         end
         pwlt_pkg::ST_FETCH1: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(1);
            p0_in    = rd_point;
            state_in = pwlt_pkg::ST_FETCHL;
         end
         pwlt_pkg::ST_FETCHL: begin
            rd_en    = 1'b1;
            rd_addr  = last_addr;
            x1_in    = rd_point.x;
            state_in = pwlt_pkg::ST_DECIDE;
         end
         pwlt_pkg::ST_DECIDE: begin
            // rd_point holds the last used point; prefetch the one below it
            hi_in   = rd_point;
            idx_in  = last_addr - AW'(1);
            rd_en   = 1'b1;
            rd_addr = last_addr - AW'(1);
            desc_in = x1_ff < p0_ff.x;
            if (p0_ff.x < x1_ff) begin
               if (query_ff > rd_point.x) begin
                  res_value_in  = rd_point.y;
                  res_region_in = pwlt_pkg::REGION_LAST;
                  state_in      = pwlt_pkg::ST_RESULT;
               end else if (query_ff <= p0_ff.x) begin
                  res_value_in  = p0_ff.y;
                  res_region_in = pwlt_pkg::REGION_FIRST;
                  state_in      = pwlt_pkg::ST_RESULT;
               end else begin
                  state_in = pwlt_pkg::ST_SCAN;
               end
            end else if (x1_ff < p0_ff.x) begin
               if (query_ff < rd_point.x) begin
                  res_value_in  = rd_point.y;
                  res_region_in = pwlt_pkg::REGION_LAST;
                  state_in      = pwlt_pkg::ST_RESULT;
               end else if (query_ff >= p0_ff.x) begin
                  res_value_in  = p0_ff.y;
                  res_region_in = pwlt_pkg::REGION_FIRST;
                  state_in      = pwlt_pkg::ST_RESULT;
               end else begin
                  state_in = pwlt_pkg::ST_SCAN;
               end
            end else begin
               res_value_in  = '0;
               res_region_in = pwlt_pkg::REGION_NONE;
               state_in      = pwlt_pkg::ST_RESULT;
            end
         end
         pwlt_pkg::ST_SCAN: begin
            // walk top down, so the first hit is the highest segment
            if (seg_hit) begin
               a_in     = desc_ff ? hi_ff : rd_point;
               b_in     = desc_ff ? rd_point : hi_ff;
               state_in = pwlt_pkg::ST_START;
            end else if (idx_ff == '0) begin
               res_value_in  = '0;
               res_region_in = pwlt_pkg::REGION_NONE;
               state_in      = pwlt_pkg::ST_RESULT;
            end else begin
               hi_in   = rd_point;
               idx_in  = idx_ff - AW'(1);
               rd_en   = 1'b1;
               rd_addr = idx_ff - AW'(1);
            end
         end
         pwlt_pkg::ST_START: begin
            istart   = 1'b1;
            state_in = pwlt_pkg::ST_WAIT;
         end
         pwlt_pkg::ST_WAIT: begin
            if (irsp.done) begin
               res_value_in  = irsp.value;
               res_region_in = pwlt_pkg::REGION_INTERP;
               state_in      = pwlt_pkg::ST_RESULT;
            end
         end
         pwlt_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_value_ff;
               rsp_region_in = res_region_ff;
               state_in      = pwlt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwlt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwlt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      p0_ff         <= p0_in;
      x1_ff         <= x1_in;
      hi_ff         <= hi_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      idx_ff        <= idx_in;
      desc_ff       <= desc_in;
      res_value_ff  <= res_value_in;
      res_region_ff <= res_region_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_region_ff;

endmodule

`default_nettype wire
